@@ rtl/core/fwbu_pkg.sv @@
// ----------------------------------------------------------------------------
// fwbu_pkg: shared types and constants of the fixed-width bit unpacker
// Register indexes, reset values, port widths and the control/status
// bundles that join the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package fwbu_pkg;

    // Configuration port
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_VALUE_COUNT = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FIELD_WIDTH = 8'd1;

    localparam int COUNT_REG_W = 16;
    localparam int WIDTH_REG_W = 6;

    localparam logic [COUNT_REG_W-1:0] VALUE_COUNT_RST = 16'd1;
    localparam logic [WIDTH_REG_W-1:0] FIELD_WIDTH_RST = 6'd8;

    // Stream payloads
    localparam int BYTE_W   = 8;
    localparam int VALUE_W  = 32;
    localparam int S_USER_W = 1;
    localparam int M_USER_W = 1;

    // Defaults of the top-level parameters
    localparam int MAX_WIDTH_DEF  = 32;
    localparam int COUNT_BITS_DEF = 16;

    // Controller -> datapath commands
    typedef struct packed {
        logic load;   // take a new byte into the shift register
        logic step;   // consume one bit of the current byte
        logic move;   // transfer the pending value into the output register
    } fwbu_cmd_t;

    // Datapath -> controller status
    typedef struct packed {
        logic completes;   // the next bit completes a value
        logic block_end;   // that value also completes the block
        logic last_bit;    // the next bit is bit 0 of the byte
        logic pend_valid;
        logic pend_final;  // pending value is the last of its byte
        logic out_free;    // output register can take a value this cycle
    } fwbu_status_t;

endpackage

`default_nettype wire

@@ rtl/core/fwbu_ctrl.sv @@
// ----------------------------------------------------------------------------
// fwbu_ctrl: sequencing of the bit unpacker
// Walks each byte one bit per cycle and stalls when a completed value has
// nowhere to go.
// ----------------------------------------------------------------------------
`default_nettype none

module fwbu_ctrl
    import fwbu_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire fwbu_status_t st,
    output fwbu_cmd_t         cmd
);

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_SHIFT = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic   busy;
    logic   last_step;

    assign busy      = (state_reg == ST_SHIFT);
    assign last_step = st.last_bit || (st.completes && st.block_end);

    always_comb begin
        cmd.move = st.out_free && st.pend_valid && (st.pend_final || (busy && st.completes));
        cmd.step = busy && (!(st.completes && st.pend_valid) || cmd.move);
        s_tready = !busy || (cmd.step && last_step);
        cmd.load = s_tvalid && s_tready;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (cmd.load) state_next = ST_SHIFT;
            end
            ST_SHIFT: begin
                if (cmd.step && last_step && !cmd.load) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/fwbu_datapath.sv @@
// ----------------------------------------------------------------------------
// fwbu_datapath: bit store, counters, pending and output registers
// Holds the configuration, assembles values bit by bit and buffers one
// completed value until its last-of-byte flag is known.
// ----------------------------------------------------------------------------
`default_nettype none

module fwbu_datapath
    import fwbu_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic [BYTE_W-1:0]      s_tdata,
    input  wire logic                   cfg_valid,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    input  wire fwbu_cmd_t              cmd,
    output fwbu_status_t                st,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [VALUE_W-1:0]          m_tdata,
    output logic [M_USER_W-1:0]         m_tuser,
    output logic                        m_tlast
);

    localparam int HW   = $clog2(MAX_WIDTH + 1);
    localparam int CMPW = WIDTH_REG_W + 1;

    logic [COUNT_REG_W-1:0] count_reg;
    logic [WIDTH_REG_W-1:0] fw_reg;

    logic [MAX_WIDTH-1:0]  store_reg;
    logic [HW-1:0]         held_reg;
    logic [COUNT_BITS-1:0] done_reg;
    logic [BYTE_W-1:0]     byte_reg;
    logic [2:0]            bitcnt_reg;

    logic               pend_valid_reg;
    logic               pend_final_reg;
    logic               pend_blk_reg;
    logic [VALUE_W-1:0] pend_value_reg;

    logic               out_valid_reg;
    logic               out_byte_reg;
    logic               out_blk_reg;
    logic [VALUE_W-1:0] out_value_reg;

    logic [CMPW-1:0]              wsel;
    logic [HW-1:0]                w;
    logic [COUNT_BITS+15:0]       count_ext;
    logic [COUNT_BITS-1:0]        target;
    logic [COUNT_BITS-1:0]        done_next;
    logic [HW-1:0]                held_inc;
    logic [MAX_WIDTH-1:0]         store_new;
    logic [MAX_WIDTH+VALUE_W-1:0] store_ext;
    logic                         completes;
    logic                         block_end;
    logic                         last_step;
    logic                         cfg_hit;

    // Width in use: zero acts as one, oversize clamps to MAX_WIDTH
    always_comb begin
        if (fw_reg == '0) begin
            wsel = CMPW'(1);
        end else if ({1'b0, fw_reg} > CMPW'(MAX_WIDTH)) begin
            wsel = CMPW'(MAX_WIDTH);
        end else begin
            wsel = {1'b0, fw_reg};
        end
    end
    assign w = wsel[HW-1:0];

    assign count_ext = (COUNT_BITS + 16)'(count_reg);
    assign target    = count_ext[COUNT_BITS-1:0];
    assign done_next = done_reg + COUNT_BITS'(1);
    assign held_inc  = held_reg + HW'(1);
    assign store_new = {store_reg[MAX_WIDTH-2:0], byte_reg[BYTE_W-1]};
    assign store_ext = (MAX_WIDTH + VALUE_W)'(store_new);
    assign completes = (held_inc >= w);
    assign block_end = (done_next == target);
    assign last_step = (bitcnt_reg == 3'd7) || (completes && block_end);

    assign cfg_hit = cfg_valid &&
                     (cfg_index == REG_VALUE_COUNT || cfg_index == REG_FIELD_WIDTH);

    always_comb begin
        st.completes  = completes;
        st.block_end  = block_end;
        st.last_bit   = (bitcnt_reg == 3'd7);
        st.pend_valid = pend_valid_reg;
        st.pend_final = pend_final_reg;
        st.out_free   = !out_valid_reg || m_tready;
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= VALUE_COUNT_RST;
            fw_reg    <= FIELD_WIDTH_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_VALUE_COUNT: count_reg <= cfg_data[COUNT_REG_W-1:0];
                REG_FIELD_WIDTH: fw_reg    <= cfg_data[WIDTH_REG_W-1:0];
                default: ;
            endcase
        end
    end

    // Bit assembly and block counting
    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_hit) begin
            store_reg <= '0;
            held_reg  <= '0;
            done_reg  <= '0;
        end else if (cmd.step) begin
            if (completes) begin
                store_reg <= '0;
                held_reg  <= '0;
                done_reg  <= block_end ? '0 : done_next;
            end else begin
                store_reg <= store_new;
                held_reg  <= held_inc;
            end
        end
    end

    // Byte shift register
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            byte_reg   <= s_tdata;
            bitcnt_reg <= '0;
        end else if (cmd.step) begin
            byte_reg   <= {byte_reg[BYTE_W-2:0], 1'b0};
            bitcnt_reg <= bitcnt_reg + 3'd1;
        end
    end

    // Pending value: waits until the next value or the end of its byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
            pend_final_reg <= 1'b0;
        end else if (cmd.step && completes) begin
            pend_valid_reg <= 1'b1;
            pend_final_reg <= last_step;
        end else if (cmd.move) begin
            pend_valid_reg <= 1'b0;
        end else if (cmd.step && last_step && pend_valid_reg) begin
            pend_final_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.step && completes) begin
            pend_value_reg <= store_ext[VALUE_W-1:0];
            pend_blk_reg   <= block_end;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.move) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.move) begin
            out_value_reg <= pend_value_reg;
            out_byte_reg  <= pend_final_reg;
            out_blk_reg   <= pend_blk_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_value_reg;
    assign m_tuser  = out_byte_reg;
    assign m_tlast  = out_blk_reg;

endmodule

`default_nettype wire

@@ rtl/core/fixed_width_bit_unpacker_top.sv @@
// ----------------------------------------------------------------------------
// fixed_width_bit_unpacker_top: MSB-first fixed-width bit unpacker
//
// Slave stream: one packed byte per transfer in s_tdata. The bits are read
// most significant first and cut into unsigned values of field_width bits.
// Master stream: one value per transfer, right aligned in m_tdata. m_tuser
// flags the last value a byte produced; m_tlast flags the value that
// completes value_count values. After that value the rest of the byte is
// padding and is dropped; the next byte opens a fresh block.
// Configuration: cfg_index 0 writes value_count, 1 writes field_width; any
// such write restarts the block. Write only while the block is idle.
// Timing: one bit of the byte is consumed per cycle by the bit sequencer
// while it is not stalled, and the next byte is taken in the cycle its last
// bit is consumed. A value reaches the master side through the pending and
// output registers in turn, since it waits in the pending register until it
// is known whether it ends its byte.
// Reset (aresetn low, synchronous) restores value_count 1 and field_width 8
// and empties the block. When the receiver stalls, hold the output value;
// bit consumption halts only when a newly completed value finds both the
// pending and output registers occupied.
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_width_bit_unpacker_top
    import fwbu_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    // slave stream
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [BYTE_W-1:0]      s_tdata,   // [7:0] data_byte
    // master stream
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [VALUE_W-1:0]          m_tdata,   // [31:0] value
    output logic [M_USER_W-1:0]         m_tuser,   // [0] last_of_byte
    output logic                        m_tlast,   // last_of_block
    // configuration write channel
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    fwbu_cmd_t    cmd;
    fwbu_status_t st;

    // Register writes are always accepted
    assign cfg_ready = 1'b1;

    fwbu_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    fwbu_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .st        (st),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // A completed value never overwrites a pending one still waiting
    a_no_pend_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.step && st.completes) |-> (!st.pend_valid || cmd.move))
        else $error("pending value overwritten");

    // Only a held value is transferred to the output register
    a_move_has_data: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.move |-> (st.pend_valid && st.out_free))
        else $error("move without pending value or free output");

    // The value that closes a block also closes its byte
    a_block_ends_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> m_tuser[0])
        else $error("block end without last-of-byte flag");

endmodule

`default_nettype wire
